// File: sv/edes_pkg.sv
`default_nettype none

package edes_pkg;

  localparam int DEF_NUM_EVENTS = 8;
  localparam int DEF_TIME_BITS  = 32;

  localparam int KIND_W = 3;
  localparam int EV_W   = 3;
  localparam int PORT_TIME_W = 32;

  // Deadline written by an enqueue that dispatches at once
  localparam int IMMEDIATE_DEADLINE = 1;

  localparam logic [KIND_W-1:0] KIND_SCHEDULE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ENQUEUE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FREEZE   = 3'd4;

  // Per-beat outcome of the slot update, carried to the result stage
  typedef struct packed {
    logic            dv;
    logic [EV_W-1:0] dtype;
    logic            busy;
    logic            frozen;
  } edes_step_t;

endpackage

`default_nettype wire

// File: sv/edes_min_tree.sv
`default_nettype none

module edes_min_tree #(
  parameter int NUM_EVENTS = edes_pkg::DEF_NUM_EVENTS,
  parameter int TIME_BITS  = edes_pkg::DEF_TIME_BITS,
  parameter int IDX_W      = $clog2(NUM_EVENTS)
) (
  input  logic [TIME_BITS-1:0] slots [NUM_EVENTS],
  output logic                 min_valid,
  output logic [IDX_W-1:0]     min_idx,
  output logic [TIME_BITS-1:0] min_time
);

  import edes_pkg::*;

  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;

  logic                 node_valid [NODES];
  logic [IDX_W-1:0]     node_idx   [NODES];
  logic [TIME_BITS-1:0] node_time  [NODES];

  // Leaves in index order; zero means unscheduled
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < NUM_EVENTS) begin : g_real
      assign node_valid[LEAVES-1+i] = (slots[i] != '0);
      assign node_time[LEAVES-1+i]  = slots[i];
    end else begin : g_pad
      assign node_valid[LEAVES-1+i] = 1'b0;
      assign node_time[LEAVES-1+i]  = '0;
    end
    assign node_idx[LEAVES-1+i] = IDX_W'(i);
  end

  // Right child wins only when strictly earlier: ties keep the lower index
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic take_r;
    assign take_r = node_valid[2*n+2] &&
                    (!node_valid[2*n+1] || (node_time[2*n+2] < node_time[2*n+1]));
    assign node_valid[n] = node_valid[2*n+1] || node_valid[2*n+2];
    assign node_idx[n]   = take_r ? node_idx[2*n+2]  : node_idx[2*n+1];
    assign node_time[n]  = take_r ? node_time[2*n+2] : node_time[2*n+1];
  end

  assign min_valid = node_valid[0];
  assign min_idx   = node_idx[0];
  assign min_time  = node_time[0];

endmodule

`default_nettype wire

// File: sv/edes_slot_ctrl.sv
`default_nettype none

module edes_slot_ctrl #(
  parameter int NUM_EVENTS = edes_pkg::DEF_NUM_EVENTS,
  parameter int TIME_BITS  = edes_pkg::DEF_TIME_BITS,
  parameter int IDX_W      = $clog2(NUM_EVENTS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [edes_pkg::KIND_W-1:0]   kind,
  input  logic [edes_pkg::EV_W-1:0]     ev,
  input  logic [TIME_BITS-1:0]          dl,
  input  logic [TIME_BITS-1:0]          now_t,
  input  logic                          min_valid,
  input  logic [IDX_W-1:0]              min_idx,
  input  logic [TIME_BITS-1:0]          min_time,
  output logic [TIME_BITS-1:0]          slots [NUM_EVENTS],
  output edes_pkg::edes_step_t          step
);

  import edes_pkg::*;

  localparam logic [TIME_BITS-1:0] IMM_T = TIME_BITS'(IMMEDIATE_DEADLINE);

  logic [TIME_BITS-1:0] slots_next [NUM_EVENTS];
  logic                 busy;
  logic                 busy_next;
  logic                 frozen;
  logic                 frozen_next;
  logic                 in_range;
  logic                 idle;
  logic                 tick_go;
  logic [IDX_W+2:0]     ev_w;
  logic [IDX_W-1:0]     ev_idx;
  logic [IDX_W-1:0]     imm_idx;
  logic [IDX_W-1:0]     disp_idx;
  logic [IDX_W+2:0]     disp_w;
  logic                 dv;

  assign in_range = (32'(ev) < 32'(NUM_EVENTS));
  assign idle     = !busy && !frozen;
  assign ev_w     = {{IDX_W{1'b0}}, ev};
  assign ev_idx   = ev_w[IDX_W-1:0];
  assign tick_go  = idle && min_valid && (min_time <= now_t);

  // Enqueue while idle: the new slot holds the smallest nonzero deadline,
  // so the winner is the lowest slot holding that value, the new slot included
  always_comb begin
    imm_idx = ev_idx;
    for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
      if (slots[i] == IMM_T) begin
        imm_idx = IDX_W'(i);
      end
    end
    if (ev_idx < imm_idx) begin
      imm_idx = ev_idx;
    end
  end

  always_comb begin
    slots_next  = slots;
    busy_next   = busy;
    frozen_next = frozen;
    dv          = 1'b0;
    disp_idx    = '0;
    case (kind)
      KIND_SCHEDULE: begin
        if (in_range) begin
          slots_next[ev_idx] = dl;
        end
      end
      KIND_ENQUEUE: begin
        if (in_range) begin
          if (idle) begin
            slots_next[ev_idx]  = IMM_T;
            slots_next[imm_idx] = '0;
            busy_next           = 1'b1;
            dv                  = 1'b1;
            disp_idx            = imm_idx;
          end else begin
            slots_next[ev_idx] = now_t;
          end
        end
      end
      KIND_TICK: begin
        if (tick_go) begin
          slots_next[min_idx] = '0;
          busy_next           = 1'b1;
          dv                  = 1'b1;
          disp_idx            = min_idx;
        end
      end
      KIND_DONE: begin
        busy_next = 1'b0;
      end
      KIND_FREEZE: begin
        frozen_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign disp_w      = {3'b000, disp_idx};
  assign step.dv     = dv;
  assign step.dtype  = disp_w[EV_W-1:0];
  assign step.busy   = busy_next;
  assign step.frozen = frozen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_EVENTS; i++) begin
        slots[i] <= '0;
      end
      busy   <= 1'b0;
      frozen <= 1'b0;
    end else if (en) begin
      slots  <= slots_next;
      busy   <= busy_next;
      frozen <= frozen_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/earliest_deadline_event_slots.sv
`default_nettype none

// Earliest-deadline event slot table. One deadline slot per event type
// (zero = unscheduled); each input beat is a schedule, enqueue, tick, done
// or freeze, and yields exactly one result beat giving any dispatch it
// caused, the earliest pending slot (lowest index on ties), the seconds left
// to it (zero once due), and the busy and halted flags after the update.
// Throughput is one beat per clock while no result beat is held. A beat
// passes three registers (input register, slot update, result register)
// before its result beat is offered. Throughput is set by the slot update:
// a single compare tree over all slots feeds both the tick decision and the
// slot write, and the same tree, once the slot registers hold the update,
// yields the earliest-slot report of the beat just applied.
// The pipeline advances as a whole; while a result beat is held by out_stall
// the block stalls its input. Slots, busy and halted clear on reset.

module earliest_deadline_event_slots #(
  parameter int NUM_EVENTS = edes_pkg::DEF_NUM_EVENTS,
  parameter int TIME_BITS  = edes_pkg::DEF_TIME_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [edes_pkg::KIND_W-1:0]       kind,
  input  logic [edes_pkg::EV_W-1:0]         event_type,
  input  logic [edes_pkg::PORT_TIME_W-1:0]  deadline,
  input  logic [edes_pkg::PORT_TIME_W-1:0]  now,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              dispatch_valid,
  output logic [edes_pkg::EV_W-1:0]         dispatch_type,
  output logic                              next_valid,
  output logic [edes_pkg::EV_W-1:0]         earliest_type,
  output logic [edes_pkg::PORT_TIME_W-1:0]  next_delay,
  output logic                              busy_res,
  output logic                              halted
);

  import edes_pkg::*;

  localparam int IDX_W = $clog2(NUM_EVENTS);
  localparam int PTW   = PORT_TIME_W;

  // Pipeline advance: everything moves unless a result beat is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Input register
  logic                 s1_valid;
  logic [KIND_W-1:0]    s1_kind;
  logic [EV_W-1:0]      s1_ev;
  logic [TIME_BITS-1:0] s1_dl;
  logic [TIME_BITS-1:0] s1_now;

  // Inputs resized to the slot width (truncate or zero-extend)
  logic [TIME_BITS+PTW-1:0] dl_w;
  logic [TIME_BITS+PTW-1:0] now_w;
  assign dl_w  = {{TIME_BITS{1'b0}}, deadline};
  assign now_w = {{TIME_BITS{1'b0}}, now};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      s1_kind <= kind;
      s1_ev   <= event_type;
      s1_dl   <= dl_w[TIME_BITS-1:0];
      s1_now  <= now_w[TIME_BITS-1:0];
    end
  end

  // Earliest slot over the current slot registers. In the update cycle it
  // drives the tick decision; the cycle after, it is the post-update view
  // of the beat now in the second stage.
  logic [TIME_BITS-1:0] slots [NUM_EVENTS];
  logic                 min_valid;
  logic [IDX_W-1:0]     min_idx;
  logic [TIME_BITS-1:0] min_time;

  edes_min_tree #(
    .NUM_EVENTS (NUM_EVENTS),
    .TIME_BITS  (TIME_BITS),
    .IDX_W      (IDX_W)
  ) u_tree (
    .slots     (slots),
    .min_valid (min_valid),
    .min_idx   (min_idx),
    .min_time  (min_time)
  );

  edes_step_t step;

  edes_slot_ctrl #(
    .NUM_EVENTS (NUM_EVENTS),
    .TIME_BITS  (TIME_BITS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .en        (en && s1_valid),
    .kind      (s1_kind),
    .ev        (s1_ev),
    .dl        (s1_dl),
    .now_t     (s1_now),
    .min_valid (min_valid),
    .min_idx   (min_idx),
    .min_time  (min_time),
    .slots     (slots),
    .step      (step)
  );

  // Second stage: outcome of the slot update
  logic                 s2_valid;
  edes_step_t           s2_step;
  logic [TIME_BITS-1:0] s2_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_step <= step;
      s2_now  <= s1_now;
    end
  end

  // Earliest-slot report: remaining time, floored at zero and
  // saturated to the port width
  logic [TIME_BITS-1:0]     delay_full;
  logic [TIME_BITS+PTW-1:0] delay_w;
  logic [PTW-1:0]           delay_port;
  logic [IDX_W+2:0]         ntype_w;

  assign delay_full = (min_valid && (min_time > s2_now)) ? (min_time - s2_now) : '0;
  assign delay_w    = {{PTW{1'b0}}, delay_full};
  assign delay_port = (|delay_w[TIME_BITS+PTW-1:PTW]) ? '1 : delay_w[PTW-1:0];
  assign ntype_w    = {3'b000, min_idx};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      dispatch_valid <= s2_step.dv;
      dispatch_type  <= s2_step.dv ? s2_step.dtype : '0;
      next_valid     <= min_valid;
      earliest_type  <= min_valid ? ntype_w[EV_W-1:0] : '0;
      next_delay     <= delay_port;
      busy_res       <= s2_step.busy;
      halted         <= s2_step.frozen;
    end
  end

endmodule

`default_nettype wire

// File: sv/edes_checker.sv
`default_nettype none

module edes_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [edes_pkg::KIND_W-1:0]       kind,
  input logic [edes_pkg::EV_W-1:0]         event_type,
  input logic [edes_pkg::PORT_TIME_W-1:0]  deadline,
  input logic [edes_pkg::PORT_TIME_W-1:0]  now,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              dispatch_valid,
  input logic [edes_pkg::EV_W-1:0]         dispatch_type,
  input logic                              next_valid,
  input logic [edes_pkg::EV_W-1:0]         earliest_type,
  input logic [edes_pkg::PORT_TIME_W-1:0]  next_delay,
  input logic                              busy_res,
  input logic                              halted
);

  import edes_pkg::*;

  // A dispatch always leaves the worker busy
  a_dispatch_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispatch_valid |-> busy_res)
    else $error("dispatch without busy");

  // Once halted, no result beat reports a dispatch
  a_halt_no_dispatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !dispatch_valid)
    else $error("dispatch while halted");

  // Halt is sticky from one result beat to the next
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && halted |=> !out_valid || halted)
    else $error("halt dropped");

  // Nothing pending reports neither a type nor a delay
  a_idle_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !next_valid |-> (earliest_type == '0) && (next_delay == '0))
    else $error("empty table reports a slot");

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dispatch_valid) &&
      $stable(dispatch_type) && $stable(next_valid) && $stable(earliest_type) &&
      $stable(next_delay) && $stable(busy_res) && $stable(halted))
    else $error("stalled result changed");

endmodule

bind earliest_deadline_event_slots edes_checker u_edes_checker (.*);

`default_nettype wire

// File: tb/tb_earliest_deadline_event_slots.sv
`timescale 1ns / 1ps

module tb_earliest_deadline_event_slots;
  import edes_pkg::*;

  localparam int NUM_SLOTS = DEF_NUM_EVENTS;
  localparam int TW        = PORT_TIME_W;
  // Kinds the block must pass through untouched
  localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;
  localparam int LONG_HOLD   = 60;      // receiver hold-off for the back-pressure test
  localparam int DRAIN_WAIT  = 8;       // pipeline is three deep
  localparam int CYCLE_LIMIT = 200000;

  // One result beat as the block should present it
  typedef struct packed {
    logic            dv;
    logic [EV_W-1:0] dtype;
    logic            nv;
    logic [EV_W-1:0] ntype;
    logic [TW-1:0]   delay;
    logic            busy;
    logic            halted;
  } slot_report_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [KIND_W-1:0] kind;
  logic [EV_W-1:0]   event_type;
  logic [TW-1:0]     deadline;
  logic [TW-1:0]     now;
  logic              out_valid;
  logic              out_stall;
  logic              dispatch_valid;
  logic [EV_W-1:0]   dispatch_type;
  logic              next_valid;
  logic [EV_W-1:0]   earliest_type;
  logic [TW-1:0]     next_delay;
  logic              busy_res;
  logic              halted;

  earliest_deadline_event_slots dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .event_type     (event_type),
    .deadline       (deadline),
    .now            (now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dispatch_valid (dispatch_valid),
    .dispatch_type  (dispatch_type),
    .next_valid     (next_valid),
    .earliest_type  (earliest_type),
    .next_delay     (next_delay),
    .busy_res       (busy_res),
    .halted         (halted)
  );

  // Shadow copy of the block's state
  logic [TW-1:0] slot_tbl [NUM_SLOTS];
  logic          busy_q;
  logic          frozen_q;

  slot_report_t  awaited_reports [$];
  int            mismatches;
  int            cycle_cnt;
  bit            idle_en;       // random gaps and stalls allowed
  bit            hold_req;      // ask the receiver for one long hold-off
  int            stall_left;
  logic [TW-1:0] wall_now;      // notional time, drifts forward between beats

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Earliest nonzero slot, lowest index wins a tie
  function automatic logic earliest_slot(output logic [EV_W-1:0] idx);
    logic          found;
    logic [TW-1:0] best;
    found = 1'b0;
    best  = '0;
    idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_tbl[i] != '0 && (!found || slot_tbl[i] < best)) begin
        found = 1'b1;
        best  = slot_tbl[i];
        idx   = i[EV_W-1:0];
      end
    end
    return found;
  endfunction

  // Apply one accepted beat to the shadow table and return the report it yields
  function automatic slot_report_t advance_slot_table(input logic [KIND_W-1:0] k,
                                                      input logic [EV_W-1:0] ev,
                                                      input logic [TW-1:0] dl,
                                                      input logic [TW-1:0] nw);
    slot_report_t    r;
    logic [EV_W-1:0] idx;
    logic            fire;
    r    = '0;
    fire = 1'b0;
    case (k)
      KIND_SCHEDULE: slot_tbl[ev] = dl;
      KIND_ENQUEUE: begin
        if (!busy_q && !frozen_q) begin
          slot_tbl[ev] = TW'(IMMEDIATE_DEADLINE);
          fire = 1'b1;
        end else begin
          slot_tbl[ev] = nw;   // now of zero cancels the slot
        end
      end
      KIND_TICK: begin
        if (!busy_q && !frozen_q && earliest_slot(idx) && slot_tbl[idx] <= nw)
          fire = 1'b1;
      end
      KIND_DONE:   busy_q   = 1'b0;
      KIND_FREEZE: frozen_q = 1'b1;
      default: ;
    endcase
    if (fire && earliest_slot(idx)) begin
      slot_tbl[idx] = '0;
      busy_q   = 1'b1;
      r.dv     = 1'b1;
      r.dtype  = idx;
    end
    r.nv = earliest_slot(idx);
    if (r.nv) begin
      r.ntype = idx;
      r.delay = (slot_tbl[idx] > nw) ? slot_tbl[idx] - nw : '0;
    end
    r.busy   = busy_q;
    r.halted = frozen_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TW-1:0] want,
                             input logic [TW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side first (its beat stems from an older input), then the input side
  always @(posedge clk) begin
    slot_report_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("result beat with nothing awaited");
          mismatches++;
        end else begin
          exp_r = awaited_reports.pop_front();
          check_field("dispatch_valid", TW'(exp_r.dv),     TW'(dispatch_valid));
          check_field("dispatch_type",  TW'(exp_r.dtype),  TW'(dispatch_type));
          check_field("next_valid",     TW'(exp_r.nv),     TW'(next_valid));
          check_field("earliest_type",  TW'(exp_r.ntype),  TW'(earliest_type));
          check_field("next_delay",     exp_r.delay,       next_delay);
          check_field("busy_res",       TW'(exp_r.busy),   TW'(busy_res));
          check_field("halted",         TW'(exp_r.halted), TW'(halted));
        end
      end
      if (in_valid && !in_stall)
        awaited_reports.push_back(advance_slot_table(kind, event_type, deadline, now));
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  // Exactly one assignment to out_stall per falling edge.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (idle_en && !rst && $urandom_range(4) == 0) begin
        stall_left = $urandom_range(2, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one beat; called and returning at a falling edge. Valid stays high
  // into the next beat unless a gap is drawn.
  task automatic send_beat(input logic [KIND_W-1:0] k, input logic [EV_W-1:0] ev,
                           input logic [TW-1:0] dl, input logic [TW-1:0] nw);
    int gap;
    if (idle_en && $urandom_range(3) == 0) begin
      gap = $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind       <= k;
    event_type <= ev;
    deadline   <= dl;
    now        <= nw;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly schedule / tick / done traffic around a drifting clock so that
  // deadlines fall due; now and then a fully random time or deadline.
  task automatic send_random_beat(input bit allow_freeze);
    int                pick;
    logic [KIND_W-1:0] k;
    logic [TW-1:0]     dl;
    if ($urandom_range(15) == 0)
      wall_now = $urandom();
    else
      wall_now += $urandom_range(12);
    pick = $urandom_range(99);
    if (pick < 30)                         k = KIND_SCHEDULE;
    else if (pick < 45)                    k = KIND_ENQUEUE;
    else if (pick < 75)                    k = KIND_TICK;
    else if (pick < 92)                    k = KIND_DONE;
    else if (allow_freeze && pick < 95)    k = KIND_FREEZE;
    else k = KIND_W'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST));
    pick = $urandom_range(9);
    case (pick)
      0:       dl = '0;
      1:       dl = $urandom();
      2:       dl = wall_now - $urandom_range(20);
      default: dl = wall_now + $urandom_range(40);
    endcase
    send_beat(k, EV_W'($urandom_range(NUM_SLOTS - 1)), dl, wall_now);
  endtask

  // Field extremes, every kind but freeze, tie-break and the enqueue corner cases
  task automatic test_directed;
    send_beat(KIND_TICK,     3'd0, 32'h0,        32'h0);          // empty table
    send_beat(KIND_SCHEDULE, 3'd0, 32'hFFFFFFFF, 32'h0);          // widest delay
    send_beat(KIND_SCHEDULE, 3'd7, 32'd100,      32'd50);
    send_beat(KIND_TICK,     3'd7, 32'd0,        32'd50);         // not yet due
    send_beat(KIND_TICK,     3'd0, 32'd0,        32'd100);        // due: slot 7 goes
    send_beat(KIND_ENQUEUE,  3'd3, 32'd0,        32'd0);          // busy, now zero
    send_beat(KIND_ENQUEUE,  3'd4, 32'd0,        32'd200);        // busy: slot at now
    send_beat(KIND_DONE,     3'd0, 32'd0,        32'd200);
    send_beat(KIND_DONE,     3'd0, 32'd0,        32'd200);        // done while idle
    send_beat(KIND_SCHEDULE, 3'd0, 32'd0,        32'd200);        // cancel
    send_beat(KIND_SCHEDULE, 3'd6, 32'd300,      32'd210);
    send_beat(KIND_SCHEDULE, 3'd1, 32'd300,      32'd210);        // tie, lower index
    send_beat(KIND_SCHEDULE, 3'd4, 32'd0,        32'd210);
    send_beat(KIND_TICK,     3'd0, 32'd0,        32'hFFFFFFFF);   // latest now
    send_beat(KIND_DONE,     3'd0, 32'd0,        32'd0);
    send_beat(KIND_SCHEDULE, 3'd2, 32'd1,        32'd0);
    send_beat(KIND_ENQUEUE,  3'd5, 32'hFFFFFFFF, 32'd0);          // idle: slot 2 wins
    send_beat(KIND_DONE,     3'd0, 32'd0,        32'd0);
    send_beat(KIND_ENQUEUE,  3'd5, 32'd0,        32'd0);          // idle: own slot
    send_beat(KIND_RSVD_FIRST, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_beat(KIND_RSVD_MID,   3'd0, 32'hAAAAAAAA, 32'h55555555);
    send_beat(KIND_RSVD_LAST,  3'd5, 32'h55555555, 32'hAAAAAAAA);
    send_beat(KIND_DONE,     3'd0, 32'd0,        32'd0);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_beat(1'b0);
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure;
    hold_req = 1'b1;
    repeat (40) send_random_beat(1'b0);
  endtask

  // Freeze is sticky until reset, so it comes last; no idling from here on
  task automatic test_freeze;
    idle_en = 1'b0;
    send_beat(KIND_DONE,     3'd0, 32'd0, wall_now);
    send_beat(KIND_ENQUEUE,  3'd2, 32'd0, wall_now);     // start a job
    send_beat(KIND_FREEZE,   3'd0, 32'd0, wall_now);     // busy survives
    send_beat(KIND_SCHEDULE, 3'd3, 32'd5, wall_now);
    send_beat(KIND_TICK,     3'd0, 32'd0, 32'hFFFFFFFF); // due but frozen
    send_beat(KIND_DONE,     3'd0, 32'd0, wall_now);
    send_beat(KIND_TICK,     3'd0, 32'd0, 32'hFFFFFFFF); // idle and still frozen
    send_beat(KIND_ENQUEUE,  3'd6, 32'd0, 32'd0);        // frozen: cancels
    send_beat(KIND_ENQUEUE,  3'd6, 32'd0, 32'd77);
    send_beat(KIND_FREEZE,   3'd0, 32'd0, wall_now);
    repeat (150) send_random_beat(1'b1);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_SCHEDULE;
    event_type = '0;
    deadline   = '0;
    now        = '0;
    idle_en    = 1'b0;
    hold_req   = 1'b0;
    mismatches = 0;
    cycle_cnt  = 0;
    wall_now   = 32'd1000;
    for (int i = 0; i < NUM_SLOTS; i++) slot_tbl[i] = '0;
    busy_q   = 1'b0;
    frozen_q = 1'b0;
    repeat (5) @(negedge clk);
    rst     <= 1'b0;
    idle_en  = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(1700);
    test_backpressure();
    test_freeze();

    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
